// ===== rtl/bmop_pkg.sv =====
// Package for the bracket matching opcode parser.
// Holds the request and result types, the stack interface structs, sizes and the symbol decoder.
// No dependencies.
package bmop_pkg;

    localparam int MAX_NESTING = 256;
    localparam int MAX_PROGRAM = 65536;

    localparam int NEST_W  = $clog2(MAX_NESTING + 1);
    localparam int ADDR_W  = $clog2(MAX_NESTING);
    localparam int COUNT_W = $clog2(MAX_PROGRAM + 1);

    localparam int IDX_W    = 16;
    localparam int OPCODE_W = 5;
    localparam int STATUS_W = 3;
    localparam int LENGTH_W = 17;

    localparam logic [OPCODE_W-1:0] OP_LOOP_START = 5'd13;
    localparam logic [OPCODE_W-1:0] OP_LOOP_END   = 5'd14;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING         = 3'd0,
        ST_OK              = 3'd1,
        ST_UNMATCHED_CLOSE = 3'd2,
        ST_UNMATCHED_OPEN  = 3'd3,
        ST_OVERFLOW        = 3'd4,
        ST_TOO_LONG        = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       byte_valid;
        logic       end_of_source;
    } in_item_t;

    typedef struct packed {
        logic                opcode_valid;
        logic [OPCODE_W-1:0] opcode;
        logic [IDX_W-1:0]    position;
        logic                pair_valid;
        logic [IDX_W-1:0]    pair_start;
        logic                finished;
        status_t             status;
        logic [LENGTH_W-1:0] program_length;
    } out_item_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [IDX_W-1:0] data;
    } stk_cmd_t;

    typedef struct packed {
        logic [NEST_W-1:0] depth;
        logic [IDX_W-1:0]  tos;
        logic [IDX_W-1:0]  nos;
    } stk_view_t;

    typedef struct packed {
        logic                kept;
        logic [OPCODE_W-1:0] code;
    } op_info_t;

    function automatic op_info_t decode_op(input logic [7:0] ch);
        op_info_t info;
        info.kept = 1'b1;
        info.code = '0;
        unique case (ch)
            8'h3C: info.code = 5'd0;   // <
            8'h3E: info.code = 5'd1;   // >
            8'h7E: info.code = 5'd2;   // ~
            8'h28: info.code = 5'd3;   // (
            8'h29: info.code = 5'd4;   // )
            8'h2F: info.code = 5'd5;   // /
            8'h5C: info.code = 5'd6;   // backslash
            8'h7B: info.code = 5'd7;   // {
            8'h7D: info.code = 5'd8;   // }
            8'h2B: info.code = 5'd9;   // +
            8'h2D: info.code = 5'd10;  // -
            8'h21: info.code = 5'd11;  // !
            8'h3F: info.code = 5'd12;  // ?
            8'h5B: info.code = OP_LOOP_START;
            8'h5D: info.code = OP_LOOP_END;
            8'h2E: info.code = 5'd15;  // .
            8'h2C: info.code = 5'd16;  // ,
            default: info.kept = 1'b0;
        endcase
        return info;
    endfunction

endpackage

// ===== rtl/bmop_stack.sv =====
// Open-bracket stack: one synchronous RAM plus top and next-below registers.
// Depends on bmop_pkg for sizes and the command/view structs.
module bmop_stack (
    input  logic                clk,
    input  logic                rst_n,
    input  bmop_pkg::stk_cmd_t  cmd,
    output bmop_pkg::stk_view_t view
);

    logic [bmop_pkg::IDX_W-1:0]  mem [bmop_pkg::MAX_NESTING];
    logic [bmop_pkg::NEST_W-1:0] depth_reg, depth_next;
    logic [bmop_pkg::IDX_W-1:0]  tos_reg, tos_next;
    logic [bmop_pkg::IDX_W-1:0]  nos_reg;
    logic [bmop_pkg::NEST_W-1:0] rd_ptr;
    logic [bmop_pkg::ADDR_W-1:0] raddr;
    logic [bmop_pkg::ADDR_W-1:0] waddr;

    always_comb
    begin
        depth_next = depth_reg;
        tos_next   = tos_reg;
        if (cmd.push)
        begin
            depth_next = depth_reg + bmop_pkg::NEST_W'(1);
            tos_next   = cmd.data;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - bmop_pkg::NEST_W'(1);
            tos_next   = nos_reg;
        end
        if (cmd.clear)
        begin
            depth_next = '0;
        end
    end

    // RAM read always tracks the entry below the new top, so it is ready for a pop next cycle
    assign rd_ptr = depth_next - bmop_pkg::NEST_W'(2);
    assign raddr  = rd_ptr[bmop_pkg::ADDR_W-1:0];
    assign waddr  = depth_reg[bmop_pkg::ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[waddr] <= cmd.data;
        end
        nos_reg <= mem[raddr];
        tos_reg <= tos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    assign view.depth = depth_reg;
    assign view.tos   = tos_reg;
    assign view.nos   = nos_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= bmop_pkg::NEST_W'(bmop_pkg::MAX_NESTING))
        else $error("stack depth above limit");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (depth_reg != '0) && !cmd.push)
        else $error("pop on empty stack or together with push");

    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && !cmd.clear) |=> (tos_reg == $past(cmd.data)))
        else $error("pushed value not on top");
`endif

endmodule

// ===== rtl/bracket_matching_opcode_parser.sv =====
// Bracket matching opcode parser.
// Source bytes enter on the item channel (valid/stall), one request per cycle while item_stall is low.
// Each symbol byte becomes a numbered opcode; all other bytes are comments and
// give no result unless marked end_of_source. A '[' pushes its index on the
// open stack, a ']' pops it and reports the matched start in pair_start.
// The end-marked request closes the program with a status in the result:
// ok, unmatched close, unmatched open (position = innermost open), nesting
// overflow or too long. After an error, requests are dropped silently up to
// and including the end-marked one, which returns the block to a fresh state.
// A result appears on the result channel in the cycle after its request is
// taken. One request per cycle is taken while item_stall is low, as the stack
// access is done at once (top entry and the entry below it are kept in registers, the RAM read
// is issued in the cycle before). A stalled result holds in the output register and
// item_stall rises until it is taken. Reset clears depth, count and the
// discard flag; the stack RAM needs no clearing pass.
// Depends on bmop_pkg and bmop_stack.
module bracket_matching_opcode_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  bmop_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output bmop_pkg::out_item_t result
);

    bmop_pkg::stk_cmd_t  stk_cmd;
    bmop_pkg::stk_view_t stk_view;

    logic [bmop_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                         discarding_reg, discarding_next;
    logic                         result_valid_reg, result_valid_next;
    bmop_pkg::out_item_t          result_reg, result_next;

    bmop_pkg::op_info_t           op_info;
    logic                         fire;
    logic                         kept;
    logic                         emit;
    logic                         err;
    logic                         push;
    logic                         pop;
    logic [bmop_pkg::NEST_W-1:0]  depth_after;
    logic [bmop_pkg::IDX_W-1:0]   tos_after;
    logic [bmop_pkg::COUNT_W-1:0] count_after;
    bmop_pkg::status_t            status;
    logic [bmop_pkg::IDX_W-1:0]   position;

    bmop_stack u_stack (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (stk_cmd),
        .view (stk_view)
    );

    assign item_stall = result_valid_reg && result_stall;
    assign fire       = item_valid && !item_stall;

    always_comb
    begin
        op_info     = bmop_pkg::decode_op(item.src_byte);
        kept        = item.byte_valid && op_info.kept;
        status      = bmop_pkg::ST_RUNNING;
        // a bare end mark reports position zero unless brackets are left open
        position    = kept ? count_reg[bmop_pkg::IDX_W-1:0] : '0;
        push        = 1'b0;
        pop         = 1'b0;

        if (kept)
        begin
            priority if (count_reg >= bmop_pkg::COUNT_W'(bmop_pkg::MAX_PROGRAM))
            begin
                status = bmop_pkg::ST_TOO_LONG;
            end
            else if (op_info.code == bmop_pkg::OP_LOOP_START)
            begin
                if (stk_view.depth == bmop_pkg::NEST_W'(bmop_pkg::MAX_NESTING))
                    status = bmop_pkg::ST_OVERFLOW;
                else
                    push = 1'b1;
            end
            else if (op_info.code == bmop_pkg::OP_LOOP_END)
            begin
                if (stk_view.depth == '0)
                    status = bmop_pkg::ST_UNMATCHED_CLOSE;
                else
                    pop = 1'b1;
            end
            else
            begin
                status = bmop_pkg::ST_RUNNING;
            end
        end
        err = (status != bmop_pkg::ST_RUNNING);

        priority if (push)
        begin
            depth_after = stk_view.depth + bmop_pkg::NEST_W'(1);
            tos_after   = count_reg[bmop_pkg::IDX_W-1:0];
        end
        else if (pop)
        begin
            depth_after = stk_view.depth - bmop_pkg::NEST_W'(1);
            tos_after   = stk_view.nos;
        end
        else
        begin
            depth_after = stk_view.depth;
            tos_after   = stk_view.tos;
        end

        count_after = (kept && !err) ? count_reg + bmop_pkg::COUNT_W'(1) : count_reg;

        if (!err && item.end_of_source)
        begin
            if (depth_after != '0)
            begin
                status   = bmop_pkg::ST_UNMATCHED_OPEN;
                position = tos_after;
            end
            else
            begin
                status = bmop_pkg::ST_OK;
            end
        end

        emit = !discarding_reg && (kept || item.end_of_source);

        result_next.opcode_valid   = kept && !err;
        result_next.opcode         = (kept && !err) ? op_info.code : '0;
        result_next.position       = position;
        result_next.pair_valid     = pop;
        result_next.pair_start     = pop ? stk_view.tos : '0;
        result_next.finished       = (status != bmop_pkg::ST_RUNNING);
        result_next.status         = status;
        result_next.program_length = bmop_pkg::LENGTH_W'(count_after);

        stk_cmd.push  = fire && !discarding_reg && push;
        stk_cmd.pop   = fire && !discarding_reg && pop;
        stk_cmd.clear = fire && item.end_of_source;
        stk_cmd.data  = count_reg[bmop_pkg::IDX_W-1:0];

        count_next      = count_reg;
        discarding_next = discarding_reg;
        if (fire)
        begin
            if (item.end_of_source)
            begin
                count_next      = '0;
                discarding_next = 1'b0;
            end
            else if (!discarding_reg)
            begin
                count_next      = count_after;
                discarding_next = err;
            end
        end

        if (fire)
            result_valid_next = emit;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            discarding_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            discarding_reg   <= discarding_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_pair_is_close: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.pair_valid) |->
            (result.opcode_valid && result.opcode == bmop_pkg::OP_LOOP_END))
        else $error("pair reported without a loop end");

    a_running_has_op: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.finished) |-> result.opcode_valid)
        else $error("running result without an opcode");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.end_of_source) |=> (count_reg == '0 && !discarding_reg))
        else $error("program state not cleared after end mark");
`endif

endmodule
